/* sv/tsfs_pkg.sv */
// ----------------------------------------------------------------------------
// tsfs_pkg
// Types and codes shared by the two-slot servo frame scheduler.
// ----------------------------------------------------------------------------
package tsfs_pkg;

  localparam logic [1:0] OP_ENQUEUE   = 2'd0;
  localparam logic [1:0] OP_DISPATCH  = 2'd1;
  localparam logic [1:0] OP_CLEAR_ONE = 2'd2;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_RDY  = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_NOTHING  = 3'd3;
  localparam logic [2:0] ST_DEFERRED = 3'd4;
  localparam logic [2:0] ST_SEND_ERR = 3'd5;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_DUAL   = 2'd2;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_RANGE = 2'd1;
  localparam logic [1:0] FAULT_TX    = 2'd2;
  localparam logic [1:0] FAULT_ARG   = 2'd3;

  localparam logic [1:0] RESP_OK   = 2'd0;
  localparam logic [1:0] RESP_BUSY = 2'd1;

  localparam logic [1:0] REG_TOOL_ENABLED  = 2'd0;
  localparam logic [1:0] REG_MAX_POSITION  = 2'd1;
  localparam logic [1:0] REG_MAX_MOVE_TIME = 2'd2;

  localparam logic [15:0] MAX_POSITION_RST  = 16'd2500;
  localparam logic [15:0] MAX_MOVE_TIME_RST = 16'd30000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        slot;
    logic [15:0] position;
    logic [15:0] move_time;
    logic [31:0] now_ms;
    logic        link_busy;
    logic [1:0]  link_response;
  } tsfs_item_t;

  typedef struct packed {
    logic        enabled;
    logic [15:0] max_pos;
    logic [15:0] max_mtime;
  } tsfs_cfg_t;

  typedef struct packed {
    logic [1:0]       valid;
    logic [1:0][15:0] pos;
    logic [1:0][15:0] mtime;
    logic [1:0][31:0] stamp;
    logic             tie_next;
    logic [1:0]       online;
    logic             ready;
    logic [1:0]       fault;
  } tsfs_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  kind;
    logic        fslot;
    logic [15:0] pos_first;
    logic [15:0] pos_second;
    logic [15:0] ftime;
    logic        over;
  } tsfs_res_t;

endpackage

/* sv/tsfs_sched.sv */
// ----------------------------------------------------------------------------
// tsfs_sched
// Per-transaction decision logic: validates enqueues, picks the frame for a
// dispatch and works out the next slot and link state.
// ----------------------------------------------------------------------------
module tsfs_sched (
  input  tsfs_pkg::tsfs_item_t  item,
  input  tsfs_pkg::tsfs_cfg_t   cfg,
  input  tsfs_pkg::tsfs_state_t cur,
  output tsfs_pkg::tsfs_state_t nxt,
  output tsfs_pkg::tsfs_res_t   res
);
  import tsfs_pkg::*;

  logic [31:0] stamp_diff;
  logic        both_valid;
  logic        pick;
  logic        resp_fail;

  assign stamp_diff = cur.stamp[0] - cur.stamp[1];
  assign both_valid = cur.valid[0] & cur.valid[1];
  assign resp_fail  = (item.link_response != RESP_OK) && (item.link_response != RESP_BUSY);

  // oldest slot by wrap-safe signed difference, alternating on equal stamps
  always_comb begin
    if (!both_valid) begin
      pick = ~cur.valid[0];
    end else if (stamp_diff == 32'd0) begin
      pick = cur.tie_next;
    end else begin
      pick = ~stamp_diff[31];
    end
  end

  always_comb begin
    nxt = cur;
    res = '0;
    res.status = ST_OK;
    res.kind   = KIND_NONE;
    case (item.opcode)
      OP_ENQUEUE: begin
        if (!cfg.enabled) begin
          res.status = ST_NOT_RDY;
          nxt.fault  = FAULT_ARG;
        end else if (item.position > cfg.max_pos || item.move_time > cfg.max_mtime) begin
          res.status = ST_INVALID;
          nxt.fault  = FAULT_RANGE;
        end else begin
          res.over              = cur.valid[item.slot];
          nxt.valid[item.slot]  = 1'b1;
          nxt.pos[item.slot]    = item.position;
          nxt.mtime[item.slot]  = item.move_time;
          nxt.stamp[item.slot]  = item.now_ms;
        end
      end
      OP_DISPATCH: begin
        if (item.link_busy || cur.valid == 2'b00) begin
          res.status = ST_NOTHING;
        end else if (both_valid && cur.mtime[0] == cur.mtime[1]) begin
          res.kind       = KIND_DUAL;
          res.pos_first  = cur.pos[0];
          res.pos_second = cur.pos[1];
          res.ftime      = cur.mtime[0];
          if (item.link_response == RESP_BUSY) begin
            res.status = ST_DEFERRED;
          end else if (!resp_fail) begin
            nxt.valid  = 2'b00;
            nxt.online = 2'b11;
            nxt.ready  = 1'b1;
            nxt.fault  = FAULT_NONE;
          end else begin
            nxt.valid  = 2'b00;
            nxt.online = 2'b00;
            nxt.ready  = 1'b0;
            nxt.fault  = FAULT_TX;
            res.status = ST_SEND_ERR;
          end
        end else begin
          res.kind      = KIND_SINGLE;
          res.fslot     = pick;
          res.pos_first = cur.pos[pick];
          res.ftime     = cur.mtime[pick];
          if (item.link_response == RESP_BUSY) begin
            res.status = ST_DEFERRED;
          end else if (!resp_fail) begin
            nxt.valid[pick]  = 1'b0;
            nxt.online[pick] = 1'b1;
            nxt.tie_next     = ~pick;
            nxt.ready        = cur.online[~pick];
            nxt.fault        = FAULT_NONE;
          end else begin
            nxt.valid[pick]  = 1'b0;
            nxt.online[pick] = 1'b0;
            nxt.ready        = 1'b0;
            nxt.fault        = FAULT_TX;
            res.status       = ST_SEND_ERR;
          end
        end
      end
      OP_CLEAR_ONE: begin
        nxt.valid[item.slot] = 1'b0;
      end
      OP_CLEAR_ALL: begin
        nxt.valid = 2'b00;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

/* sv/two_slot_servo_frame_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// two_slot_servo_frame_scheduler_unit
// Two pending servo command slots with enqueue checks and frame dispatch.
// ----------------------------------------------------------------------------
// Each transaction is registered on acceptance, decided combinationally
// against the slot state and written to the output register together with
// the updated state when that register can take it, so one transaction is
// taken per cycle while the output does not stall. The pipeline
// stalls only when the output register is full and out_ready is low.
// Configuration writes take effect at once and are expected while the block
// is idle.
module two_slot_servo_frame_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic        in_slot,
  input  logic [15:0] in_position,
  input  logic [15:0] in_move_time,
  input  logic [31:0] in_now_ms,
  input  logic        in_link_busy,
  input  logic [1:0]  in_link_response,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_frame_kind,
  output logic        out_frame_slot,
  output logic [15:0] out_frame_position_first,
  output logic [15:0] out_frame_position_second,
  output logic [15:0] out_frame_time,
  output logic        out_pending_first,
  output logic        out_pending_second,
  output logic        out_overwrote,
  output logic        out_ready_res,
  output logic [1:0]  out_fault_code
);
  import tsfs_pkg::*;

  tsfs_cfg_t   cfg_r;
  tsfs_state_t state_r;
  tsfs_state_t state_nxt;
  tsfs_item_t  item_r;
  logic        item_vld_r;
  tsfs_res_t   res_nxt;
  tsfs_res_t   res_r;
  logic        out_vld_r;
  logic        advance;

  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled   <= 1'b0;
      cfg_r.max_pos   <= MAX_POSITION_RST;
      cfg_r.max_mtime <= MAX_MOVE_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOOL_ENABLED:  cfg_r.enabled   <= cfg_wdata[0];
        REG_MAX_POSITION:  cfg_r.max_pos   <= cfg_wdata;
        REG_MAX_MOVE_TIME: cfg_r.max_mtime <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.opcode        <= in_opcode;
      item_r.slot          <= in_slot;
      item_r.position      <= in_position;
      item_r.move_time     <= in_move_time;
      item_r.now_ms        <= in_now_ms;
      item_r.link_busy     <= in_link_busy;
      item_r.link_response <= in_link_response;
    end
  end

  tsfs_sched u_sched (
    .item (item_r),
    .cfg  (cfg_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // slot state, written as the transaction moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (item_vld_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_vld_r && advance) begin
      res_r <= res_nxt;
    end
  end

  logic [1:0] pend_r;
  logic       rdy_res_r;
  logic [1:0] fault_r;

  always_ff @(posedge clk) begin
    if (item_vld_r && advance) begin
      pend_r    <= state_nxt.valid;
      rdy_res_r <= state_nxt.ready;
      fault_r   <= state_nxt.fault;
    end
  end

  assign out_valid                 = out_vld_r;
  assign out_status                = res_r.status;
  assign out_frame_kind            = res_r.kind;
  assign out_frame_slot            = res_r.fslot;
  assign out_frame_position_first  = res_r.pos_first;
  assign out_frame_position_second = res_r.pos_second;
  assign out_frame_time            = res_r.ftime;
  assign out_pending_first         = pend_r[0];
  assign out_pending_second        = pend_r[1];
  assign out_overwrote             = res_r.over;
  assign out_ready_res             = rdy_res_r;
  assign out_fault_code            = fault_r;

endmodule

/* sv/tsfs_checker.sv */
// ----------------------------------------------------------------------------
// tsfs_checker
// Port-level checks for the two-slot servo frame scheduler.
// ----------------------------------------------------------------------------
module tsfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [1:0]  out_frame_kind,
  input logic [15:0] out_frame_position_first,
  input logic [15:0] out_frame_position_second,
  input logic [15:0] out_frame_time,
  input logic        out_pending_first,
  input logic        out_pending_second,
  input logic        out_ready_res,
  input logic [1:0]  out_fault_code
);
  import tsfs_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_frame_kind))
    else $error("result changed while stalled");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind == KIND_NONE |->
      out_frame_position_first == 16'd0 && out_frame_position_second == 16'd0
      && out_frame_time == 16'd0)
    else $error("frame fields set without a frame");

  a_dual_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind == KIND_DUAL && out_status != ST_DEFERRED |->
      !out_pending_first && !out_pending_second)
    else $error("dual frame left a slot pending");

  a_send_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SEND_ERR |->
      !out_ready_res && out_fault_code == FAULT_TX && out_frame_kind != KIND_NONE)
    else $error("send failure without transmit fault");

  a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_RDY |->
      out_fault_code == FAULT_ARG && out_frame_kind == KIND_NONE)
    else $error("refused enqueue reported wrongly");

endmodule

bind two_slot_servo_frame_scheduler_unit tsfs_checker u_tsfs_checker (.*);
